### rtl/sluli_pkg.sv
// Package for the sequence list unit: action and status codes, sequencer states
// and the result record passed from the sequencer to the output stage.
// No dependencies.
package sluli_pkg;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_REMOVE  = 2'd3
  } act_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] TAG_NIL = 2'd0;

  typedef enum logic [3:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_DISPATCH,
    SEQ_RD_WAIT,
    SEQ_INS_CHK,
    SEQ_INS_SHIFT,
    SEQ_INS_WR,
    SEQ_REM_SHIFT,
    SEQ_REM_TOP,
    SEQ_SCAN_GO,
    SEQ_SCAN,
    SEQ_RESP
  } seq_state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  read_tag;
    logic [15:0] read_value;
    logic [8:0]  used_length;
  } res_t;

endpackage

### rtl/sequence_list_with_last_used_index_unit.sv
// Sequence list unit: a table of TABLE_DEPTH tagged entries (tag 0 is nil) with
// a tracked last used index. Depends on sluli_pkg, sluli_ctrl and sluli_ram.
//
// Input channel (in_valid_i/in_ready_o) takes one item: action_i (read, insert,
// replace, remove), position_i, entry_tag_i and entry_value_i. Output channel
// (out_valid_o/out_ready_i) returns one item per input: status_o, read_tag_o,
// read_value_o and used_length_o.
// The entries live in a single-port-write, single-port-read RAM, and one
// sequencer walks it one address per cycle. A read passes through the dispatch
// and read-wait states to the response state; a replace with no scan goes from
// dispatch straight to response. Insert and remove shift every entry above the
// position, one per cycle, and clearing the last entry starts a backward scan at
// one entry per cycle.
// After reset a clearing pass writes every entry nil, with
// in_ready_o low. A finished item moves into the output register; the next
// input is accepted while it waits. If the receiver stalls, the sequencer holds
// its next result until the output register frees.
module sequence_list_with_last_used_index_unit #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  position_i,
  input  logic [1:0]  entry_tag_i,
  input  logic [15:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  read_tag_o,
  output logic [15:0] read_value_o,
  output logic [8:0]  used_length_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned DW = VALUE_BITS + 2;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [DW-1:0]   ram_rdata;
  logic            res_valid;
  logic            res_ready;
  sluli_pkg::res_t res;
  sluli_pkg::res_t out_q;
  logic            out_valid_q;

  sluli_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .entry_tag_i  (entry_tag_i),
    .entry_value_i(entry_value_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  sluli_ram #(
    .WIDTH(DW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign read_tag_o    = out_q.read_tag;
  assign read_value_o  = out_q.read_value;
  assign used_length_o = out_q.used_length;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while sequencer busy");

  a_read_tag_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_tag_o != sluli_pkg::TAG_NIL) |-> status_o == sluli_pkg::STATUS_OK)
    else $error("entry returned with error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == sluli_pkg::STATUS_OK) || (status_o == sluli_pkg::STATUS_RANGE)
                    || (status_o == sluli_pkg::STATUS_FULL))
    else $error("undefined status code");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result dropped or changed");
`endif

endmodule

### rtl/sluli_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sluli_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sluli_ctrl.sv
// Sequencer of the sequence list unit: drives the entry RAM one address per cycle
// for clear, shift and backward scan, and tracks the last used index.
// Depends on sluli_pkg.
module sluli_ctrl #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic [7:0]                     position_i,
  input  logic [1:0]                     entry_tag_i,
  input  logic [15:0]                    entry_value_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output sluli_pkg::res_t                res_o,
  output logic                           ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr_o,
  output logic [VALUE_BITS+1:0]          ram_wdata_o,
  output logic                           ram_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr_o,
  input  logic [VALUE_BITS+1:0]          ram_rdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned DW = VALUE_BITS + 2;
  localparam int unsigned CW = AW + 9;
  localparam logic [AW-1:0] TOP = AW'(TABLE_DEPTH - 1);

  sluli_pkg::seq_state_e state_q, state_d;
  sluli_pkg::act_e       act_q, act_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic                  range_ok_q, range_ok_d;
  logic [1:0]            tag_q, tag_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [AW-1:0]         addr_q, addr_d;
  logic [AW-1:0]         last_q, last_d;
  logic                  has_q, has_d;
  logic [1:0]            status_q, status_d;
  logic [1:0]            rtag_q, rtag_d;
  logic [15:0]           rval_q, rval_d;

  logic [1:0]            rd_tag;
  logic [VALUE_BITS-1:0] rd_val;
  logic [DW-1:0]         new_word;
  logic                  new_nil;
  logic                  pos_le_last;
  logic                  pos_in_range;

  assign rd_tag       = ram_rdata_i[DW-1 -: 2];
  assign rd_val       = ram_rdata_i[VALUE_BITS-1:0];
  assign new_nil      = (tag_q == sluli_pkg::TAG_NIL);
  assign new_word     = {tag_q, val_q};
  assign pos_le_last  = has_q && (pos_q <= last_q);
  assign pos_in_range = (CW'(position_i) < CW'(TABLE_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sluli_pkg::SEQ_CLEAR: begin
        if (addr_q == TOP) state_d = sluli_pkg::SEQ_IDLE;
      end
      sluli_pkg::SEQ_IDLE: begin
        if (in_valid_i) state_d = sluli_pkg::SEQ_DISPATCH;
      end
      sluli_pkg::SEQ_DISPATCH: begin
        if (!range_ok_q) begin
          state_d = sluli_pkg::SEQ_RESP;
        end else begin
          unique case (act_q)
            sluli_pkg::ACT_READ:   state_d = sluli_pkg::SEQ_RD_WAIT;
            sluli_pkg::ACT_INSERT: state_d = sluli_pkg::SEQ_INS_CHK;
            sluli_pkg::ACT_REPLACE: begin
              if (new_nil && has_q && (pos_q == last_q)) state_d = sluli_pkg::SEQ_SCAN_GO;
              else state_d = sluli_pkg::SEQ_RESP;
            end
            sluli_pkg::ACT_REMOVE: begin
              if (pos_q == TOP) state_d = sluli_pkg::SEQ_REM_TOP;
              else state_d = sluli_pkg::SEQ_REM_SHIFT;
            end
            default: state_d = sluli_pkg::SEQ_RESP;
          endcase
        end
      end
      sluli_pkg::SEQ_RD_WAIT: state_d = sluli_pkg::SEQ_RESP;
      sluli_pkg::SEQ_INS_CHK: begin
        priority if (rd_tag != sluli_pkg::TAG_NIL) state_d = sluli_pkg::SEQ_RESP;
        else if (pos_q == TOP) state_d = sluli_pkg::SEQ_INS_WR;
        else state_d = sluli_pkg::SEQ_INS_SHIFT;
      end
      sluli_pkg::SEQ_INS_SHIFT: begin
        if (addr_q == pos_q) state_d = sluli_pkg::SEQ_INS_WR;
      end
      sluli_pkg::SEQ_INS_WR: state_d = sluli_pkg::SEQ_RESP;
      sluli_pkg::SEQ_REM_SHIFT: begin
        if (addr_q == TOP) state_d = sluli_pkg::SEQ_REM_TOP;
      end
      sluli_pkg::SEQ_REM_TOP: begin
        if (pos_le_last) state_d = sluli_pkg::SEQ_SCAN_GO;
        else state_d = sluli_pkg::SEQ_RESP;
      end
      sluli_pkg::SEQ_SCAN_GO: state_d = sluli_pkg::SEQ_SCAN;
      sluli_pkg::SEQ_SCAN: begin
        if ((rd_tag != sluli_pkg::TAG_NIL) || (addr_q == '0)) state_d = sluli_pkg::SEQ_RESP;
      end
      sluli_pkg::SEQ_RESP: begin
        if (res_ready_i) state_d = sluli_pkg::SEQ_IDLE;
      end
      default: state_d = sluli_pkg::SEQ_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    act_d       = act_q;
    pos_d       = pos_q;
    range_ok_d  = range_ok_q;
    tag_d       = tag_q;
    val_d       = val_q;
    addr_d      = addr_q;
    last_d      = last_q;
    has_d       = has_q;
    status_d    = status_q;
    rtag_d      = rtag_q;
    rval_d      = rval_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;
    unique case (state_q)
      sluli_pkg::SEQ_CLEAR: begin
        ram_we_o = 1'b1;
        addr_d   = addr_q + 1'b1;
      end
      sluli_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          act_d      = sluli_pkg::act_e'(action_i);
          pos_d      = AW'(position_i);
          range_ok_d = pos_in_range;
          tag_d      = entry_tag_i;
          val_d      = (entry_tag_i == sluli_pkg::TAG_NIL) ? '0 : VALUE_BITS'(entry_value_i);
          status_d   = sluli_pkg::STATUS_OK;
          rtag_d     = '0;
          rval_d     = '0;
        end
      end
      sluli_pkg::SEQ_DISPATCH: begin
        if (!range_ok_q) begin
          status_d = sluli_pkg::STATUS_RANGE;
        end else begin
          unique case (act_q)
            sluli_pkg::ACT_READ: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = pos_q;
            end
            sluli_pkg::ACT_INSERT: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = TOP;
            end
            sluli_pkg::ACT_REPLACE: begin
              ram_we_o    = 1'b1;
              ram_waddr_o = pos_q;
              ram_wdata_o = new_word;
              if (!new_nil) begin
                if (!has_q || (pos_q > last_q)) begin
                  last_d = pos_q;
                  has_d  = 1'b1;
                end
              end else if (has_q && (pos_q == last_q)) begin
                addr_d = pos_q;
              end
            end
            sluli_pkg::ACT_REMOVE: begin
              if (pos_q != TOP) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = pos_q + 1'b1;
                addr_d      = pos_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      sluli_pkg::SEQ_RD_WAIT: begin
        rtag_d = rd_tag;
        rval_d = (rd_tag != sluli_pkg::TAG_NIL) ? 16'(rd_val) : 16'd0;
      end
      sluli_pkg::SEQ_INS_CHK: begin
        if (rd_tag != sluli_pkg::TAG_NIL) begin
          status_d = sluli_pkg::STATUS_FULL;
        end else if (pos_q != TOP) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = TOP - 1'b1;
          addr_d      = TOP - 1'b1;
        end
      end
      sluli_pkg::SEQ_INS_SHIFT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_q + 1'b1;
        ram_wdata_o = ram_rdata_i;
        if (addr_q != pos_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = addr_q - 1'b1;
          addr_d      = addr_q - 1'b1;
        end
      end
      sluli_pkg::SEQ_INS_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = new_word;
        if (pos_le_last) begin
          last_d = last_q + 1'b1;
        end else if (!new_nil) begin
          last_d = pos_q;
          has_d  = 1'b1;
        end
      end
      sluli_pkg::SEQ_REM_SHIFT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_q - 1'b1;
        ram_wdata_o = ram_rdata_i;
        if (addr_q != TOP) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = addr_q + 1'b1;
          addr_d      = addr_q + 1'b1;
        end
      end
      sluli_pkg::SEQ_REM_TOP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = TOP;
        if (pos_le_last) addr_d = last_q;
      end
      sluli_pkg::SEQ_SCAN_GO: begin
        ram_re_o = 1'b1;
      end
      sluli_pkg::SEQ_SCAN: begin
        priority if (rd_tag != sluli_pkg::TAG_NIL) begin
          last_d = addr_q;
          has_d  = 1'b1;
        end else if (addr_q == '0) begin
          last_d = '0;
          has_d  = 1'b0;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = addr_q - 1'b1;
          addr_d      = addr_q - 1'b1;
        end
      end
      sluli_pkg::SEQ_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sluli_pkg::SEQ_CLEAR;
      addr_q  <= '0;
      last_q  <= '0;
      has_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      last_q  <= last_d;
      has_q   <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    pos_q      <= pos_d;
    range_ok_q <= range_ok_d;
    tag_q      <= tag_d;
    val_q      <= val_d;
    status_q   <= status_d;
    rtag_q     <= rtag_d;
    rval_q     <= rval_d;
  end

  assign in_ready_o  = (state_q == sluli_pkg::SEQ_IDLE);
  assign res_valid_o = (state_q == sluli_pkg::SEQ_RESP);

  always_comb begin
    res_o.status      = status_q;
    res_o.read_tag    = rtag_q;
    res_o.read_value  = rval_q;
    res_o.used_length = has_q ? 9'({1'b0, last_q} + (AW + 1)'(1)) : 9'd0;
  end

endmodule

### verif/sluli_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the sequence list unit: keeps its own copy of the entry table and
// last used index, predicts one result per accepted item and compares each output item.
// Depends on sluli_pkg.
module sluli_result_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  position_i,
  input  logic [1:0]  entry_tag_i,
  input  logic [15:0] entry_value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [1:0]  read_tag_i,
  input  logic [15:0] read_value_i,
  input  logic [8:0]  used_length_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [1:0]      tag_mem   [TABLE_DEPTH];
  logic [15:0]     value_mem [TABLE_DEPTH];
  int              last_idx;
  bit              any_used;
  sluli_pkg::res_t replies_due [$];
  sluli_pkg::res_t want;
  sluli_pkg::res_t got;
  int unsigned     fails;

  task automatic find_last_from(input int from);
    int i;
    any_used = 1'b0;
    last_idx = 0;
    for (i = from; i >= 0 && !any_used; i--) begin
      if (tag_mem[i] != sluli_pkg::TAG_NIL) begin
        last_idx = i;
        any_used = 1'b1;
      end
    end
  endtask

  task automatic apply_item(input sluli_pkg::act_e act, input logic [7:0] pos,
                            input logic [1:0] tag, input logic [15:0] value,
                            output sluli_pkg::res_t res);
    logic [15:0] wr_value;
    int p;
    int i;
    p = int'(pos);
    wr_value = (tag == sluli_pkg::TAG_NIL) ? 16'd0 : value;
    res = '0;
    if (p >= TABLE_DEPTH) begin
      res.status = sluli_pkg::STATUS_RANGE;
    end else begin
      case (act)
        sluli_pkg::ACT_READ: begin
          res.read_tag = tag_mem[p];
          res.read_value = (tag_mem[p] != sluli_pkg::TAG_NIL) ? value_mem[p] : 16'd0;
        end
        sluli_pkg::ACT_INSERT: begin
          if (tag_mem[TABLE_DEPTH-1] != sluli_pkg::TAG_NIL) begin
            res.status = sluli_pkg::STATUS_FULL;
          end else begin
            for (i = TABLE_DEPTH - 1; i > p; i--) begin
              tag_mem[i] = tag_mem[i-1];
              value_mem[i] = value_mem[i-1];
            end
            tag_mem[p] = tag;
            value_mem[p] = wr_value;
            if (any_used && p <= last_idx) begin
              last_idx = last_idx + 1;
            end else if (tag != sluli_pkg::TAG_NIL) begin
              last_idx = p;
              any_used = 1'b1;
            end
          end
        end
        sluli_pkg::ACT_REPLACE: begin
          tag_mem[p] = tag;
          value_mem[p] = wr_value;
          if (tag != sluli_pkg::TAG_NIL) begin
            if (!any_used || p > last_idx) begin
              last_idx = p;
              any_used = 1'b1;
            end
          end else if (any_used && p == last_idx) begin
            find_last_from(p);
          end
        end
        sluli_pkg::ACT_REMOVE: begin
          for (i = p; i + 1 < TABLE_DEPTH; i++) begin
            tag_mem[i] = tag_mem[i+1];
            value_mem[i] = value_mem[i+1];
          end
          tag_mem[TABLE_DEPTH-1] = sluli_pkg::TAG_NIL;
          value_mem[TABLE_DEPTH-1] = 16'd0;
          if (any_used && p <= last_idx) find_last_from(last_idx);
        end
      endcase
    end
    res.used_length = any_used ? 9'(last_idx + 1) : 9'd0;
  endtask

  function automatic int unsigned field_bad(string field, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v === exp_v) return 0;
    $display("%0t: %s expected %0h, got %0h", $time, field, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        tag_mem[i] = sluli_pkg::TAG_NIL;
        value_mem[i] = 16'd0;
      end
      last_idx = 0;
      any_used = 1'b0;
      replies_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: item expected none, got status %0h tag %0h value %0h length %0h",
                   $time, status_i, read_tag_i, read_value_i, used_length_i);
          fails++;
        end else begin
          want = replies_due.pop_front();
          fails += field_bad("status", 16'(want.status), 16'(status_i));
          fails += field_bad("read_tag", 16'(want.read_tag), 16'(read_tag_i));
          fails += field_bad("read_value", want.read_value, read_value_i);
          fails += field_bad("used_length", 16'(want.used_length), 16'(used_length_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_item(sluli_pkg::act_e'(action_i), position_i, entry_tag_i, entry_value_i, got);
        replies_due.push_back(got);
      end
      fail_count_o <= fails;
      pending_o <= replies_due.size();
    end
  end

endmodule

### verif/sequence_list_with_last_used_index_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for the sequence list unit: drives directed and random items with random
// idling on both channels and takes the verdict from sluli_result_checker.
// Depends on sluli_pkg, sequence_list_with_last_used_index_unit and sluli_result_checker.
module sequence_list_with_last_used_index_unit_tb;

  localparam int DEPTH        = 256;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CALM_TAIL    = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [7:0]  position;
  logic [1:0]  entry_tag;
  logic [15:0] entry_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [1:0]  read_tag;
  logic [15:0] read_value;
  logic [8:0]  used_length;
  int unsigned fails;
  int unsigned pending;

  logic [8:0]       seen_len;
  int               outs_seen;
  int               out_pct;
  sluli_pkg::act_e  r_act;
  logic [7:0]       r_pos;
  logic [1:0]       r_tag;
  int               pick;
  int               idle_pct;
  bit               grow;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sequence_list_with_last_used_index_unit #(
    .TABLE_DEPTH(DEPTH),
    .VALUE_BITS (16)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (action),
    .position_i   (position),
    .entry_tag_i  (entry_tag),
    .entry_value_i(entry_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .read_tag_o   (read_tag),
    .read_value_o (read_value),
    .used_length_o(used_length)
  );

  sluli_result_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .action_i     (action),
    .position_i   (position),
    .entry_tag_i  (entry_tag),
    .entry_value_i(entry_value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     (status),
    .read_tag_i   (read_tag),
    .read_value_i (read_value),
    .used_length_i(used_length),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  task automatic send_item(input sluli_pkg::act_e act, input logic [7:0] pos,
                           input logic [1:0] tag, input logic [15:0] value);
    in_valid <= 1'b1;
    action <= act;
    position <= pos;
    entry_tag <= tag;
    entry_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver side: random stall bursts, none near the end
  initial begin
    out_ready <= 1'b0;
    seen_len <= 9'd0;
    outs_seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        seen_len <= used_length;
        outs_seen++;
      end
      case ((outs_seen / 90) % 3)
        0: out_pct = 30;
        1: out_pct = 0;
        default: out_pct = 10;
      endcase
      if (outs_seen >= RANDOM_ITEMS - CALM_TAIL) out_pct = 0;
      if (rst_n === 1'b1 && $urandom_range(0, 99) < out_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    action <= sluli_pkg::ACT_READ;
    position <= 8'd0;
    entry_tag <= sluli_pkg::TAG_NIL;
    entry_value <= 16'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_item(sluli_pkg::ACT_READ,    8'd0,   sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_READ,    8'd255, 2'd1,               16'hFFFF);
    send_item(sluli_pkg::ACT_REMOVE,  8'd0,   sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_REPLACE, 8'd5,   sluli_pkg::TAG_NIL, 16'h1234);
    send_item(sluli_pkg::ACT_REPLACE, 8'd0,   2'd1,               16'h0001);
    send_item(sluli_pkg::ACT_REPLACE, 8'd0,   sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_INSERT,  8'd3,   2'd1,               16'hFFFF);
    send_item(sluli_pkg::ACT_INSERT,  8'd0,   2'd2,               16'h0000);
    send_item(sluli_pkg::ACT_INSERT,  8'd10,  sluli_pkg::TAG_NIL, 16'hABCD);
    send_item(sluli_pkg::ACT_INSERT,  8'd2,   sluli_pkg::TAG_NIL, 16'h5A5A);
    send_item(sluli_pkg::ACT_READ,    8'd4,   sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_READ,    8'd2,   sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_REPLACE, 8'd200, 2'd3,               16'hAAAA);
    send_item(sluli_pkg::ACT_REMOVE,  8'd100, sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_REMOVE,  8'd230, sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_REPLACE, 8'd199, sluli_pkg::TAG_NIL, 16'h1111);
    send_item(sluli_pkg::ACT_REPLACE, 8'd254, 2'd1,               16'h5555);
    send_item(sluli_pkg::ACT_INSERT,  8'd0,   2'd2,               16'h8001);
    send_item(sluli_pkg::ACT_INSERT,  8'd7,   2'd1,               16'h0F0F);
    send_item(sluli_pkg::ACT_READ,    8'd255, sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_REMOVE,  8'd255, sluli_pkg::TAG_NIL, 16'h0000);
    send_item(sluli_pkg::ACT_REMOVE,  8'd0,   2'd3,               16'h7FFF);
    send_item(sluli_pkg::ACT_REPLACE, 8'd255, 2'd3,               16'hFFFF);
    send_item(sluli_pkg::ACT_INSERT,  8'd255, 2'd1,               16'h0001);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      grow = ((n / 150) % 2) == 0;
      case ((n / 100) % 3)
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (n >= RANDOM_ITEMS - CALM_TAIL) idle_pct = 0;

      pick = $urandom_range(0, 99);
      if (grow) begin
        r_act = pick < 45 ? sluli_pkg::ACT_INSERT : pick < 65 ? sluli_pkg::ACT_REPLACE :
                pick < 80 ? sluli_pkg::ACT_READ : sluli_pkg::ACT_REMOVE;
      end else begin
        r_act = pick < 40 ? sluli_pkg::ACT_REMOVE : pick < 60 ? sluli_pkg::ACT_REPLACE :
                pick < 80 ? sluli_pkg::ACT_READ : sluli_pkg::ACT_INSERT;
      end

      // aim at the last used index and its neighbors as well as the table ends
      case ($urandom_range(0, 5))
        0: r_pos = 8'($urandom_range(0, 255));
        1: r_pos = (seen_len == 9'd0) ? 8'd0 : 8'(seen_len - 9'd1);
        2: r_pos = (seen_len > 9'd255) ? 8'd255 : 8'(seen_len);
        3: r_pos = 8'($urandom_range(0, 15));
        4: r_pos = 8'($urandom_range(240, 255));
        default: r_pos = 8'($urandom_range(0, (seen_len == 9'd0) ? 0 : int'(seen_len) - 1));
      endcase
      r_tag = ($urandom_range(0, 4) == 0) ? sluli_pkg::TAG_NIL : 2'($urandom_range(1, 3));

      if ($urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      send_item(r_act, r_pos, r_tag, 16'($urandom));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
